### design/robin_hood_hash_table_top_defines.svh
// assertion macros for the robin hood hash table
// used by robin_hood_hash_table_top, which must have clk and arst_n in scope
`ifndef ROBIN_HOOD_HASH_TABLE_TOP_DEFINES_SVH
`define ROBIN_HOOD_HASH_TABLE_TOP_DEFINES_SVH

// same-cycle implication
`define RHHT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RHHT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/rhht_pkg.sv
// package for the robin hood hash table: operation and status codes, defaults
// no dependencies
package rhht_pkg;
	localparam int HASH_W = 32;
	localparam int OP_W = 2;
	localparam int ST_W = 2;
	localparam int FILL_W = 9;

	localparam int DEF_TABLE_SLOTS = 256;
	localparam int DEF_HANDLE_BITS = 16;
	localparam int DEF_NAME_BITS = 16;
	localparam logic [FILL_W-1:0] FILL_LIMIT_RESET = 9'd224;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

	localparam logic [ST_W-1:0] STAT_DONE = 2'd0;
	localparam logic [ST_W-1:0] STAT_EXISTS = 2'd1;
	localparam logic [ST_W-1:0] STAT_FULL = 2'd2;
	localparam logic [ST_W-1:0] STAT_MISSING = 2'd3;
endpackage

### design/robin_hood_hash_table_top.sv
// robin hood hash table with backward-shift removal, top level
// depends on rhht_pkg and robin_hood_hash_table_top_defines.svh
//
// One item is one operation (insert, lookup, remove, clear) and gives one
// result item. All slots live in a single synchronous memory (one read, one
// write per cycle), and each step of a probe, place or shift walk is a read,
// then a check; the place and shift checks may write the slot back. An
// operation holds the block while it probes its slots and, for an insert or
// remove, walks its place or shift slots; a remove ends with a closing write.
// When TABLE_SLOTS is not a power of two the home slot is found first by a
// reciprocal multiplication for the quotient, then by a multiply-subtract for
// the remainder. Clear sweeps the memory one slot a cycle; the same sweep
// runs after reset, and no item is accepted until it ends (configuration
// writes are always taken). The finished result sits in an output register,
// so the next item is taken while it waits. fill_limit must only be written
// while the table is idle.
module robin_hood_hash_table_top #(
	parameter int TABLE_SLOTS = rhht_pkg::DEF_TABLE_SLOTS,
	parameter int HANDLE_BITS = rhht_pkg::DEF_HANDLE_BITS,
	parameter int NAME_BITS = rhht_pkg::DEF_NAME_BITS,
	parameter int COUNT_W = $clog2(TABLE_SLOTS + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rhht_pkg::OP_W-1:0]     operation,
	input  logic [rhht_pkg::HASH_W-1:0]   name_hash,
	input  logic [NAME_BITS-1:0]          name_id,
	input  logic [HANDLE_BITS-1:0]        symbol_handle,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rhht_pkg::ST_W-1:0]     status,
	output logic [HANDLE_BITS-1:0]        found_handle,
	output logic [COUNT_W-1:0]            entry_count,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rhht_pkg::FILL_W-1:0]   cfg_data
);
	import rhht_pkg::*;

	`include "robin_hood_hash_table_top_defines.svh"

	localparam int IDX_W = $clog2(TABLE_SLOTS);
	localparam int DIST_W = IDX_W + 1;
	localparam bit IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
	// reciprocal for hash / TABLE_SLOTS, exact over all 32-bit hashes
	localparam int RCP_SH = HASH_W + IDX_W;
	localparam logic [HASH_W:0] RCP_MUL =
		(HASH_W + 1)'((64'd1 << RCP_SH) / 64'(TABLE_SLOTS) + 64'd1);
	localparam logic [HASH_W-1:0] SLOTS_H = HASH_W'(TABLE_SLOTS);

	// controller states
	localparam int SW = 4;
	localparam logic [SW-1:0] S_CLR    = 4'd0;
	localparam logic [SW-1:0] S_IDLE   = 4'd1;
	localparam logic [SW-1:0] S_MOD    = 4'd2;
	localparam logic [SW-1:0] S_PR_RD  = 4'd3;
	localparam logic [SW-1:0] S_PR_CHK = 4'd4;
	localparam logic [SW-1:0] S_PL_RD  = 4'd5;
	localparam logic [SW-1:0] S_PL_CHK = 4'd6;
	localparam logic [SW-1:0] S_SH_RD  = 4'd7;
	localparam logic [SW-1:0] S_SH_CHK = 4'd8;
	localparam logic [SW-1:0] S_SH_END = 4'd9;
	localparam logic [SW-1:0] S_DONE   = 4'd10;

	// one slot of the table; a zero hash means empty
	typedef struct packed {
		logic [HASH_W-1:0]      hash;
		logic [DIST_W-1:0]      pdist;
		logic [NAME_BITS-1:0]   name;
		logic [HANDLE_BITS-1:0] handle;
	} entry_t;

	entry_t slot_mem [TABLE_SLOTS];
	entry_t rd_q;
	entry_t mem_wdata;
	logic mem_we;
	logic [IDX_W-1:0] mem_raddr;

	logic [SW-1:0] state_q;
	logic [OP_W-1:0] op_q;
	logic [HASH_W-1:0] hash_q;        // probe key, later the travelling entry
	logic [NAME_BITS-1:0] name_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic [IDX_W-1:0] slot_q;         // current slot, also sweep index
	logic [IDX_W-1:0] home_q;
	logic [DIST_W-1:0] dist_q;
	logic [IDX_W-1:0] steps_q;
	logic mod_phase_q;                // home slot: quotient, then remainder
	logic [HASH_W-1:0] quo_q;
	logic report_q;                   // sweep came from a clear item
	logic [COUNT_W-1:0] count_q;
	logic [FILL_W-1:0] fill_limit_q;
	logic [ST_W-1:0] res_status_q;
	logic [HANDLE_BITS-1:0] res_handle_q;

	logic out_valid_q;
	logic [ST_W-1:0] out_status_q;
	logic [HANDLE_BITS-1:0] out_handle_q;
	logic [COUNT_W-1:0] out_count_q;

	logic [IDX_W-1:0] slot_next;
	logic [2*HASH_W:0] rcp_prod;
	logic [HASH_W-1:0] mod_rem;
	logic key_hit;
	logic table_full;
	logic out_load;

	assign slot_next = (slot_q == LAST_IDX) ? '0 : slot_q + 1'b1;
	assign rcp_prod = (2 * HASH_W + 1)'(hash_q) * (2 * HASH_W + 1)'(RCP_MUL);
	assign mod_rem = hash_q - HASH_W'(quo_q * SLOTS_H);
	assign key_hit = (rd_q.hash == hash_q) && ((op_q == OP_REMOVE) ?
		(rd_q.handle == handle_q) : (rd_q.name == name_q));
	assign table_full = (32'(count_q) >= 32'(fill_limit_q))
		|| (32'(count_q) >= 32'(TABLE_SLOTS));
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	assign in_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign found_handle = out_handle_q;
	assign entry_count = out_count_q;

	// shift walk reads one ahead of the slot it rewrites
	assign mem_raddr = (state_q == S_SH_RD) ? slot_next : slot_q;

	// write side: always at the current slot
	always_comb begin
		mem_we = 1'b0;
		mem_wdata = '0;
		unique case (state_q)
			S_CLR, S_SH_END: begin
				mem_we = 1'b1;
			end
			S_PL_CHK: begin
				if (rd_q.hash == '0 || dist_q > rd_q.pdist) begin
					mem_we = 1'b1;
					mem_wdata = '{hash: hash_q, pdist: dist_q, name: name_q,
						handle: handle_q};
				end
			end
			S_SH_CHK: begin
				if (rd_q.hash != '0 && rd_q.pdist != '0) begin
					mem_we = 1'b1;
					mem_wdata = '{hash: rd_q.hash, pdist: rd_q.pdist - DIST_W'(1),
						name: rd_q.name, handle: rd_q.handle};
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[slot_q] <= mem_wdata;
		end
		rd_q <= slot_mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_limit_q <= FILL_LIMIT_RESET;
		end else if (cfg_valid) begin
			fill_limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			slot_q <= '0;
			report_q <= 1'b0;
			count_q <= '0;
			op_q <= OP_INSERT;
			home_q <= '0;
			dist_q <= '0;
			steps_q <= '0;
			mod_phase_q <= 1'b0;
			quo_q <= '0;
			res_status_q <= STAT_DONE;
			res_handle_q <= '0;
			hash_q <= '0;
			name_q <= '0;
			handle_q <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					slot_q <= slot_next;
					if (slot_q == LAST_IDX) begin
						count_q <= '0;
						res_status_q <= STAT_DONE;
						res_handle_q <= '0;
						state_q <= report_q ? S_DONE : S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						op_q <= operation;
						hash_q <= (name_hash == '0) ? HASH_W'(1) : name_hash;
						name_q <= name_id;
						handle_q <= symbol_handle;
						dist_q <= '0;
						steps_q <= '0;
						res_handle_q <= '0;
						if (operation == OP_CLEAR) begin
							slot_q <= '0;
							report_q <= 1'b1;
							state_q <= S_CLR;
						end else if (operation == OP_REMOVE && count_q == '0) begin
							res_status_q <= STAT_MISSING;
							state_q <= S_DONE;
						end else if (IS_POW2) begin
							slot_q <= name_hash[IDX_W-1:0] | IDX_W'(name_hash == '0);
							home_q <= name_hash[IDX_W-1:0] | IDX_W'(name_hash == '0);
							state_q <= S_PR_RD;
						end else begin
							mod_phase_q <= 1'b0;
							state_q <= S_MOD;
						end
					end
				end
				S_MOD: begin
					// quotient by reciprocal, then remainder by multiply-subtract
					if (!mod_phase_q) begin
						quo_q <= HASH_W'(rcp_prod >> RCP_SH);
						mod_phase_q <= 1'b1;
					end else begin
						slot_q <= mod_rem[IDX_W-1:0];
						home_q <= mod_rem[IDX_W-1:0];
						state_q <= S_PR_RD;
					end
				end
				S_PR_RD: begin
					state_q <= S_PR_CHK;
				end
				S_PR_CHK: begin
					if (rd_q.hash != '0 && !(dist_q > rd_q.pdist) && key_hit) begin
						res_status_q <= (op_q == OP_INSERT) ? STAT_EXISTS : STAT_DONE;
						res_handle_q <= (op_q == OP_REMOVE) ? '0 : rd_q.handle;
						steps_q <= '0;
						state_q <= (op_q == OP_REMOVE) ? S_SH_RD : S_DONE;
					end else if (rd_q.hash == '0 || dist_q > rd_q.pdist
							|| dist_q == DIST_W'(TABLE_SLOTS - 1)) begin
						// miss
						if (op_q != OP_INSERT) begin
							res_status_q <= STAT_MISSING;
							state_q <= S_DONE;
						end else if (table_full) begin
							res_status_q <= STAT_FULL;
							state_q <= S_DONE;
						end else begin
							slot_q <= home_q;
							dist_q <= '0;
							steps_q <= '0;
							state_q <= S_PL_RD;
						end
					end else begin
						slot_q <= slot_next;
						dist_q <= dist_q + 1'b1;
						state_q <= S_PR_RD;
					end
				end
				S_PL_RD: begin
					state_q <= S_PL_CHK;
				end
				S_PL_CHK: begin
					slot_q <= slot_next;
					steps_q <= steps_q + 1'b1;
					state_q <= S_PL_RD;
					if (rd_q.hash == '0 || steps_q == LAST_IDX) begin
						count_q <= count_q + 1'b1;
						res_status_q <= STAT_DONE;
						state_q <= S_DONE;
					end else if (dist_q > rd_q.pdist) begin
						// swap: the resident entry travels on
						hash_q <= rd_q.hash;
						name_q <= rd_q.name;
						handle_q <= rd_q.handle;
						dist_q <= rd_q.pdist + 1'b1;
					end else begin
						dist_q <= dist_q + 1'b1;
					end
				end
				S_SH_RD: begin
					state_q <= S_SH_CHK;
				end
				S_SH_CHK: begin
					if (rd_q.hash == '0 || rd_q.pdist == '0) begin
						state_q <= S_SH_END;
					end else begin
						slot_q <= slot_next;
						steps_q <= steps_q + 1'b1;
						state_q <= (steps_q == LAST_IDX) ? S_SH_END : S_SH_RD;
					end
				end
				S_SH_END: begin
					count_q <= count_q - 1'b1;
					res_status_q <= STAT_DONE;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						report_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status_q;
			out_handle_q <= res_handle_q;
			out_count_q <= count_q;
		end
	end

	`RHHT_ASSERT_NOW(a_count_bound, 1'b1, 32'(count_q) <= 32'(TABLE_SLOTS),
		"entry count above table size")
	`RHHT_ASSERT_NOW(a_probe_no_write, state_q == S_PR_CHK || state_q == S_PR_RD,
		!mem_we, "memory written during probe")
	`RHHT_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready,
		"item accepted while another is in flight")
	`RHHT_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid,
		"pending result dropped")
endmodule

### tb/sv/tb.sv
// testbench for robin_hood_hash_table_top: directed and random table operations
// keeps its own copy of the table and checks every result item in order
// depends on rhht_pkg and the design files
`timescale 1ns / 1ps

module tb;
	import rhht_pkg::*;

	localparam int SLOTS = DEF_TABLE_SLOTS;
	localparam int SWEEP_WAIT = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [OP_W-1:0] operation = OP_INSERT;
	logic [HASH_W-1:0] name_hash = '0;
	logic [15:0] name_id = '0;
	logic [15:0] symbol_handle = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [ST_W-1:0] status;
	logic [15:0] found_handle;
	logic [8:0] entry_count;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [FILL_W-1:0] cfg_data = '0;

	robin_hood_hash_table_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .name_hash(name_hash), .name_id(name_id),
		.symbol_handle(symbol_handle),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .found_handle(found_handle), .entry_count(entry_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	typedef struct packed {
		logic [ST_W-1:0] stat;
		logic [15:0] handle;
		logic [8:0] count;
	} table_result_t;

	// shadow copy of the table
	logic [31:0] sh_hash [SLOTS];
	logic [8:0] sh_dist [SLOTS];
	logic [15:0] sh_name [SLOTS];
	logic [15:0] sh_handle [SLOTS];
	int unsigned sh_count;
	logic [FILL_W-1:0] sh_limit;

	table_result_t pending_results[$];
	int unsigned mismatch_count = 0;
	int unsigned items_sent = 0;
	int unsigned results_seen = 0;
	int unsigned full_seen = 0;
	int unsigned exists_seen = 0;
	int unsigned rx_idle = 0;
	bit idle_enable = 1'b1;
	bit drain_stall = 1'b0;

	// keys that were inserted, for well-formed lookups and removes
	logic [31:0] known_hash[$];
	logic [15:0] known_name[$];
	logic [15:0] known_handle[$];

	function automatic void table_wipe();
		for (int i = 0; i < SLOTS; i++) begin
			sh_hash[i] = '0;
			sh_dist[i] = '0;
			sh_name[i] = '0;
			sh_handle[i] = '0;
		end
		sh_count = 0;
	endfunction

	// probe by name or by handle, -1 when absent
	function automatic int find_slot(logic [31:0] h, logic [15:0] key, bit by_handle);
		int s;
		s = h % SLOTS;
		for (int d = 0; d < SLOTS; d++) begin
			if (sh_hash[s] == 0 || d > sh_dist[s])
				return -1;
			if (sh_hash[s] == h && (by_handle ? sh_handle[s] : sh_name[s]) == key)
				return s;
			s = (s + 1) % SLOTS;
		end
		return -1;
	endfunction

	function automatic void robin_place(logic [31:0] h, logic [15:0] nm, logic [15:0] hd);
		int s;
		logic [8:0] pdist;
		logic [31:0] th;
		logic [8:0] td;
		logic [15:0] tn, tk;
		s = h % SLOTS;
		pdist = 0;
		for (int n = 0; n < SLOTS; n++) begin
			if (sh_hash[s] == 0) begin
				sh_hash[s] = h; sh_dist[s] = pdist; sh_name[s] = nm; sh_handle[s] = hd;
				return;
			end
			if (pdist > sh_dist[s]) begin
				th = sh_hash[s]; td = sh_dist[s]; tn = sh_name[s]; tk = sh_handle[s];
				sh_hash[s] = h; sh_dist[s] = pdist; sh_name[s] = nm; sh_handle[s] = hd;
				h = th; pdist = td; nm = tn; hd = tk;
			end
			s = (s + 1) % SLOTS;
			pdist++;
		end
	endfunction

	function automatic void shift_back(int s);
		int nx;
		for (int n = 0; n < SLOTS; n++) begin
			nx = (s + 1) % SLOTS;
			if (sh_hash[nx] == 0 || sh_dist[nx] == 0)
				break;
			sh_hash[s] = sh_hash[nx]; sh_dist[s] = sh_dist[nx] - 1;
			sh_name[s] = sh_name[nx]; sh_handle[s] = sh_handle[nx];
			s = nx;
		end
		sh_hash[s] = 0; sh_dist[s] = 0; sh_name[s] = 0; sh_handle[s] = 0;
	endfunction

	// applies one operation to the shadow table and gives its result
	function automatic table_result_t table_apply(logic [OP_W-1:0] op, logic [31:0] h,
			logic [15:0] nm, logic [15:0] hd);
		table_result_t r;
		int s;
		r.stat = STAT_DONE;
		r.handle = '0;
		if (h == 0)
			h = 1;
		case (op)
			OP_INSERT: begin
				s = find_slot(h, nm, 1'b0);
				if (s >= 0) begin
					r.stat = STAT_EXISTS;
					r.handle = sh_handle[s];
				end else if (sh_count >= sh_limit || sh_count >= SLOTS) begin
					r.stat = STAT_FULL;
				end else begin
					robin_place(h, nm, hd);
					sh_count++;
				end
			end
			OP_LOOKUP: begin
				s = find_slot(h, nm, 1'b0);
				if (s >= 0)
					r.handle = sh_handle[s];
				else
					r.stat = STAT_MISSING;
			end
			OP_REMOVE: begin
				s = (sh_count == 0) ? -1 : find_slot(h, hd, 1'b1);
				if (s >= 0) begin
					shift_back(s);
					sh_count--;
				end else begin
					r.stat = STAT_MISSING;
				end
			end
			default: table_wipe();
		endcase
		r.count = sh_count[8:0];
		return r;
	endfunction

	// sender gap: valid drops for the length of the burst
	task automatic idle_burst();
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
	endtask

	// sends one item, predicting its result at acceptance
	task automatic send_op(logic [OP_W-1:0] op, logic [31:0] h, logic [15:0] nm,
			logic [15:0] hd);
		idle_burst();
		operation <= op;
		name_hash <= h;
		name_id <= nm;
		symbol_handle <= hd;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		pending_results.push_back(table_apply(op, h, nm, hd));
		items_sent++;
		if (op == OP_INSERT) begin
			known_hash.push_back(h);
			known_name.push_back(nm);
			known_handle.push_back(hd);
			if (known_hash.size() > 300) begin
				void'(known_hash.pop_front());
				void'(known_name.pop_front());
				void'(known_handle.pop_front());
			end
		end
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SWEEP_WAIT) @(negedge clk);
	endtask

	// fill_limit write, table must be idle
	task automatic write_limit(logic [FILL_W-1:0] v);
		drain();
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		sh_limit = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// receiver with random stall bursts, or a long hold-off when asked
	always @(negedge clk) begin
		if (drain_stall) begin
			out_ready <= 1'b0;
		end else if (rx_idle != 0) begin
			rx_idle--;
			out_ready <= 1'b0;
		end else if (idle_enable && $urandom_range(0, 9) == 0) begin
			rx_idle = $urandom_range(0, 7);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		table_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result item: status %0d handle %0h count %0d",
						status, found_handle, entry_count);
			end else begin
				exp_r = pending_results.pop_front();
				if (exp_r.stat == STAT_FULL) full_seen++;
				if (exp_r.stat == STAT_EXISTS) exists_seen++;
				if (status !== exp_r.stat || found_handle !== exp_r.handle ||
						entry_count !== exp_r.count) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected %0d/%0h/%0d got %0d/%0h/%0d",
							exp_r.stat, exp_r.handle, exp_r.count,
							status, found_handle, entry_count);
				end
			end
		end
	end

	// random hash with home slots packed into a few buckets now and then
	function automatic logic [31:0] rand_hash();
		case ($urandom_range(0, 3))
			0: return {16'($urandom_range(0, 65535)), 8'd0, 8'($urandom_range(0, 7))};
			1: return 32'($urandom) & 32'h0000_0003;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed();
		// empty table cases
		send_op(OP_REMOVE, 32'd5, 16'd1, 16'd1);
		send_op(OP_LOOKUP, 32'd5, 16'd1, 16'd1);
		// zero hash is treated as one
		send_op(OP_INSERT, 32'd0, 16'h0000, 16'hFFFF);
		send_op(OP_LOOKUP, 32'd1, 16'h0000, 16'h0000);
		send_op(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000);
		// duplicate name
		send_op(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 16'h1234);
		// collisions on the last slot wrap around
		send_op(OP_INSERT, 32'h0000_01FF, 16'h0010, 16'h0A0A);
		send_op(OP_INSERT, 32'h0000_00FF, 16'h0011, 16'h5555);
		send_op(OP_INSERT, 32'h0000_0100, 16'h0012, 16'hAAAA);
		send_op(OP_LOOKUP, 32'h0000_00FF, 16'h0011, 16'h0);
		// remove with wrong handle, then right, with backward shift
		send_op(OP_REMOVE, 32'hFFFF_FFFF, 16'h0, 16'h0001);
		send_op(OP_REMOVE, 32'hFFFF_FFFF, 16'h0, 16'h0000);
		send_op(OP_LOOKUP, 32'h0000_0100, 16'h0012, 16'h0);
		send_op(OP_CLEAR, 32'h0, 16'h0, 16'h0);
		send_op(OP_LOOKUP, 32'h0000_00FF, 16'h0011, 16'h0);
	endtask

	task automatic test_fill_limit(logic [FILL_W-1:0] lim, int n);
		write_limit(lim);
		for (int i = 0; i < n; i++)
			send_op(OP_INSERT, rand_hash(), 16'($urandom), 16'($urandom));
		send_op(OP_CLEAR, $urandom, 16'($urandom), 16'($urandom));
	endtask

	task automatic random_ops(int n);
		int k;
		logic [OP_W-1:0] op;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (k < 45)
				send_op(OP_INSERT, rand_hash(), 16'($urandom_range(0, 511)), 16'($urandom));
			else if (k < 70 && known_hash.size() != 0) begin
				k = $urandom_range(0, known_hash.size() - 1);
				op = $urandom_range(0, 1) ? OP_REMOVE : OP_LOOKUP;
				send_op(op, known_hash[k], known_name[k], known_handle[k]);
			end else if (k < 98)
				send_op(2'($urandom_range(0, 2)), rand_hash(), 16'($urandom), 16'($urandom));
			else
				send_op(OP_CLEAR, $urandom, 16'($urandom), 16'($urandom));
		end
	endtask

	// receiver stops for a long time while the sender keeps offering items
	task automatic test_backpressure();
		fork
			begin
				drain_stall = 1'b1;
				repeat (300) @(negedge clk);
				drain_stall = 1'b0;
			end
			random_ops(40);
		join
	endtask

	initial begin
		table_wipe();
		sh_limit = FILL_LIMIT_RESET;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_fill_limit(9'd1, 4);
		test_fill_limit(9'd256, 270);
		test_fill_limit(9'd0, 3);
		test_fill_limit(9'd511, 10);
		write_limit(9'd40);
		random_ops(300);
		test_backpressure();
		write_limit(FILL_LIMIT_RESET);
		random_ops(250);
		// last stretch runs at full rate
		idle_enable = 1'b0;
		random_ops(120);
		drain();
		$display("covered %0d items, %0d results, %0d full and %0d duplicate refusals",
			items_sent, results_seen, full_seen, exists_seen);
		$display("fill limits 0, 1, 40, 224, 256 and 511 used, one long output stall");
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#100ms;
		$display("tb: failure");
		$finish;
	end
endmodule

### robin_hood_hash_table_top.f
+incdir+design
design/rhht_pkg.sv
design/robin_hood_hash_table_top.sv
tb/sv/tb.sv
